>>> rtl/gsf_pkg.sv
// Shared types and constants for the GPS sentence framer.
package gsf_pkg;

    // Default buffer depths
    localparam int BINARY_DEPTH_DEF = 256;
    localparam int TEXT_DEPTH_DEF   = 128;

    // Framing characters and the length byte position
    localparam logic [7:0] CH_START   = 8'h24;  // '$'
    localparam logic [7:0] CH_BINARY  = 8'h40;  // '@'
    localparam logic [7:0] CH_NEWLINE = 8'h0A;  // newline
    localparam logic [7:0] LENGTH_POS = 8'd6;

    // Framer state carried between bytes
    typedef struct packed {
        logic [7:0] frame_position;
        logic       is_binary_record;
        logic [7:0] record_length;
    } frame_state_t;

    // One result item
    typedef struct packed {
        logic       write_binary;
        logic       write_text;
        logic [7:0] write_index;
        logic [7:0] write_data;
        logic       frame_done;
    } frame_result_t;

endpackage

>>> rtl/gsf_decode.sv
// Per-byte framing decision: result item and next framer state.
module gsf_decode #(
    parameter int BINARY_DEPTH = gsf_pkg::BINARY_DEPTH_DEF,
    parameter int TEXT_DEPTH   = gsf_pkg::TEXT_DEPTH_DEF
) (
    input  logic [7:0]            rx_byte,
    input  gsf_pkg::frame_state_t state,
    output gsf_pkg::frame_state_t state_next,
    output gsf_pkg::frame_result_t result
);

    localparam logic [8:0] BIN_DEPTH = 9'(BINARY_DEPTH);
    localparam logic [8:0] TXT_DEPTH = 9'(TEXT_DEPTH);
    localparam logic [7:0] BIN_LAST  = 8'(BINARY_DEPTH - 1);
    localparam logic [7:0] TXT_LAST  = 8'(TEXT_DEPTH - 1);

    logic [8:0] pos_inc;
    logic [8:0] next_pos;
    logic [8:0] depth;
    logic [7:0] last_idx;
    logic       kind_next;

    assign pos_inc = {1'b0, state.frame_position} + 9'd1;

    // Main framing decision
    always_comb
    begin
        result                = '0;
        kind_next             = state.is_binary_record;
        state_next            = state;
        next_pos              = 9'd0;
        last_idx              = state.is_binary_record ? BIN_LAST : TXT_LAST;

        if (state.frame_position == 8'd0)
        begin
            if (rx_byte == gsf_pkg::CH_START)
            begin
                result.write_binary = 1'b1;
                result.write_text   = 1'b1;
                result.write_data   = rx_byte;
                next_pos            = 9'd1;
            end
        end
        else if (state.frame_position == 8'd1)
        begin
            // Kind byte is always stored, '$' included
            kind_next           = (rx_byte == gsf_pkg::CH_BINARY);
            result.write_binary = kind_next;
            result.write_text   = !kind_next;
            result.write_index  = 8'd1;
            result.write_data   = rx_byte;
            next_pos            = 9'd2;
        end
        else if (state.frame_position == gsf_pkg::LENGTH_POS && state.is_binary_record)
        begin
            state_next.record_length = rx_byte;
            result.write_binary      = 1'b1;
            result.write_index       = state.frame_position;
            result.write_data        = rx_byte;
            next_pos                 = pos_inc;
        end
        else if (rx_byte == gsf_pkg::CH_NEWLINE ||
                 (state.is_binary_record && state.frame_position == state.record_length))
        begin
            // Ending byte is not stored
            result.frame_done = state.is_binary_record;
        end
        else if (rx_byte != gsf_pkg::CH_START)
        begin
            // Body byte, index saturated at the last entry
            result.write_index  = (state.frame_position < last_idx) ?
                                  state.frame_position : last_idx;
            result.write_data   = rx_byte;
            result.write_binary = state.is_binary_record;
            result.write_text   = !state.is_binary_record;
            next_pos            = pos_inc;
        end

        // Wrap at the depth of the kind now in force; next_pos never exceeds it
        depth                       = kind_next ? BIN_DEPTH : TXT_DEPTH;
        state_next.is_binary_record = kind_next;
        state_next.frame_position   = (next_pos >= depth) ? 8'(next_pos - depth)
                                                          : next_pos[7:0];
    end

endmodule

>>> rtl/gps_sentence_framer_unit.sv
// Top level of the GPS sentence framer: input register, decode, result register.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------------------
//  rx      | rx_valid     | rx_stall     | rx_byte
//  result  | result_valid | result_stall | write_binary, write_text, write_index,
//          |              |              | write_data, frame_done
//
// One byte is taken per cycle while rx_stall is low; each byte gives one result,
// passing through the input register, the single decode step and the result register.
// Framer state changes as a byte moves from the input register to the result
// register. Reset clears state and both valid flags. While result_stall holds a
// full result register, a full input register holds too and rx_stall rises; an
// empty input register still takes one byte before rx_stall rises.
module gps_sentence_framer_unit #(
    parameter int BINARY_DEPTH = gsf_pkg::BINARY_DEPTH_DEF,
    parameter int TEXT_DEPTH   = gsf_pkg::TEXT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       write_binary,
    output logic       write_text,
    output logic [7:0] write_index,
    output logic [7:0] write_data,
    output logic       frame_done
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    gsf_pkg::frame_result_t out_reg;
    gsf_pkg::frame_state_t  state_reg;
    gsf_pkg::frame_state_t  state_next;
    gsf_pkg::frame_result_t result_next;
    logic                   advance;

    // Byte moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || !result_stall);
    assign rx_stall = in_valid_reg && !advance;

    gsf_decode #(
        .BINARY_DEPTH (BINARY_DEPTH),
        .TEXT_DEPTH   (TEXT_DEPTH)
    ) u_decode (
        .rx_byte    (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!rx_stall)
            begin
                in_valid_reg <= rx_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign write_binary = out_reg.write_binary;
    assign write_text   = out_reg.write_text;
    assign write_index  = out_reg.write_index;
    assign write_data   = out_reg.write_data;
    assign frame_done   = out_reg.frame_done;

endmodule

>>> rtl/gsf_checker.sv
// Port-level checks for the GPS sentence framer, bound to the top level.
module gsf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic       write_binary,
    input logic       write_text,
    input logic [7:0] write_index,
    input logic [7:0] write_data,
    input logic       frame_done
);

    // Storing to both buffers happens only for the opening '$' at index 0
    a_both_open: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && write_binary && write_text
        |-> write_index == 8'd0 && write_data == gsf_pkg::CH_START)
        else $error("dual store other than frame opening");

    // A completed record stores nothing
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_done
        |-> !write_binary && !write_text && write_index == 8'd0 && write_data == 8'd0)
        else $error("frame_done with a store");

    // No store means zero index and data
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !write_binary && !write_text
        |-> write_index == 8'd0 && write_data == 8'd0)
        else $error("nonzero payload without store");

    // A stalled result stays valid and holds its data, index and frame_done
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall
        |=> result_valid && $stable(write_data) && $stable(write_index)
            && $stable(frame_done))
        else $error("stalled result changed");

endmodule

bind gps_sentence_framer_unit gsf_checker u_gsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .write_binary (write_binary),
    .write_text   (write_text),
    .write_index  (write_index),
    .write_data   (write_data),
    .frame_done   (frame_done)
);
